>>> sv/cpe_pkg.sv
// Shared types and codes for the complex polynomial evaluator.
// Holds the payload structs, the multiplier step codes and the request codes.
// No dependencies.
`default_nettype none

package cpe_pkg;

    // Request codes carried in req_type.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [3:0]        coeff_index;
        logic signed [31:0] value_re;
        logic signed [31:0] value_im;
    } t_cpe_in;

    typedef struct packed {
        logic signed [31:0] result_re;
        logic signed [31:0] result_im;
        logic              overflow;
    } t_cpe_out;

    // One complex Q-format value as kept in the coefficient table.
    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } t_cpx;

    // Multiplier step codes: which operand pair the shared multiplier takes.
    typedef logic [2:0] t_step;
    localparam t_step S_CR_PR = 3'd0;
    localparam t_step S_CI_PI = 3'd1;
    localparam t_step S_CR_PI = 3'd2;
    localparam t_step S_CI_PR = 3'd3;
    localparam t_step S_PR_XR = 3'd4;
    localparam t_step S_PI_XI = 3'd5;
    localparam t_step S_PR_XI = 3'd6;
    localparam t_step S_PI_XR = 3'd7;

    typedef struct packed {
        logic               valid;
        t_step              step;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               valid;
        t_step              step;
        logic signed [63:0] prod;
    } t_mul_rsp;

endpackage

`default_nettype wire

>>> sv/complex_polynomial_evaluator.sv
// Complex polynomial evaluator: a load item is written into the coefficient table; an
// evaluate item is accepted, prefetches coefficient 0, runs the multiplier steps of each
// term on the single shared 32 x 32 multiplier, drains and then loads the output
// register once the output is not stalled. The input is stalled meanwhile, so a new
// evaluate is not taken before the last result is loaded. Reset (synchronous, active low)
// clears the table's valid bits, so all entries read as zero, and zeroes the degree.
`default_nettype none

module complex_polynomial_evaluator
    import cpe_pkg::*;
#(
    parameter int MAX_TERMS = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_cpe_in    i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output t_cpe_out        o_out_data,
    input  wire logic       i_cfg_we,
    input  wire logic [3:0] i_cfg_wdata
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;
    localparam logic signed [31:0] ONE     = 32'sd1 <<< FRAC_BITS;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PREF  = 5'b00010,
        ST_RUN   = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_HOLD  = 5'b10000
    } t_state;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } t_sat;

    // Shift a full-precision sum down by the fraction width and clamp it.
    function automatic t_sat sat_shift(input logic signed [65:0] v);
        logic signed [65:0] s;
        t_sat               r;
        s = v >>> FRAC_BITS;
        if (s > SAT_MAX) begin
            r.ovf = 1'b1;
            r.val = 32'sh7fffffff;
        end else if (s < SAT_MIN) begin
            r.ovf = 1'b1;
            r.val = 32'sh80000000;
        end else begin
            r.ovf = 1'b0;
            r.val = s[31:0];
        end
        return r;
    endfunction

    function automatic t_sat sat_add(input logic signed [31:0] a,
                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        t_sat               r;
        s = {a[31], a} + {b[31], b};
        r.ovf = s[32] ^ s[31];
        if (r.ovf) begin
            r.val = s[32] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            r.val = s[31:0];
        end
        return r;
    endfunction

    t_state             r_state, n_state;
    logic [3:0]         r_degree;
    t_step              r_step, n_step;
    logic [AW-1:0]      r_term, n_term;
    logic signed [31:0] r_xr, n_xr, r_xi, n_xi;
    logic signed [31:0] r_pr, n_pr, r_pi, n_pi;
    logic signed [31:0] r_accr, n_accr, r_acci, n_acci;
    logic signed [31:0] r_t, n_t;
    logic signed [65:0] r_sum, n_sum;
    logic               r_ovf, n_ovf;
    logic               r_ov, n_ov;
    t_cpe_out           r_out, n_out;

    logic          accept;
    logic [AW-1:0] last;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_cpx          coef;
    t_cpx          wr_data;
    t_mul_req      mreq;
    t_mul_rsp      mrsp;
    logic signed [65:0] p66;
    t_sat          sres;

    assign accept  = i_in_valid && !o_in_stall;
    assign wr_en   = accept && (i_in_data.req_type == REQ_LOAD)
                     && (32'(i_in_data.coeff_index) < MAX_TERMS);
    assign wr_data = '{re: i_in_data.value_re, im: i_in_data.value_im};
    assign p66     = {{2{mrsp.prod[63]}}, mrsp.prod};

    always_comb begin
        if (32'(r_degree) > MAX_TERMS - 1) begin
            last = AW'(MAX_TERMS - 1);
        end else begin
            last = AW'(r_degree);
        end
    end

    // The next coefficient is fetched while the power update runs.
    assign rd_en   = (r_state == ST_PREF)
                     || ((r_state == ST_RUN) && (r_step == S_PR_XR) && (r_term != last));
    assign rd_addr = (r_state == ST_PREF) ? '0 : r_term + AW'(1);

    cpe_coef_mem #(
        .DEPTH (MAX_TERMS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_en),
        .i_waddr (AW'(i_in_data.coeff_index)),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (coef)
    );

    always_comb begin
        mreq.valid = (r_state == ST_RUN);
        mreq.step  = r_step;
        case (r_step)
            S_CR_PR: begin mreq.a = coef.re; mreq.b = r_pr; end
            S_CI_PI: begin mreq.a = coef.im; mreq.b = r_pi; end
            S_CR_PI: begin mreq.a = coef.re; mreq.b = r_pi; end
            S_CI_PR: begin mreq.a = coef.im; mreq.b = r_pr; end
            S_PR_XR: begin mreq.a = r_pr;    mreq.b = r_xr; end
            S_PI_XI: begin mreq.a = r_pi;    mreq.b = r_xi; end
            S_PR_XI: begin mreq.a = r_pr;    mreq.b = r_xi; end
            S_PI_XR: begin mreq.a = r_pi;    mreq.b = r_xr; end
            default: begin mreq.a = r_pr;    mreq.b = r_xr; end
        endcase
    end

    cpe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rsp   (mrsp)
    );

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_term  = r_term;
        n_xr    = r_xr;
        n_xi    = r_xi;
        n_pr    = r_pr;
        n_pi    = r_pi;
        n_accr  = r_accr;
        n_acci  = r_acci;
        n_t     = r_t;
        n_sum   = r_sum;
        n_ovf   = r_ovf;
        n_ov    = r_ov && i_out_stall;
        n_out   = r_out;
        sres    = '0;

        // Products come back in the cycle after issue; odd steps close a sum.
        if (mrsp.valid) begin
            case (mrsp.step)
                S_CR_PR, S_PR_XR, S_PR_XI: begin
                    n_sum = p66;
                end
                S_CR_PI: begin
                    n_sum  = p66;
                    sres   = sat_add(r_accr, r_t);
                    n_accr = sres.val;
                    n_ovf  = r_ovf | sres.ovf;
                end
                S_CI_PI: begin
                    sres  = sat_shift(r_sum - p66);
                    n_t   = sres.val;
                    n_ovf = r_ovf | sres.ovf;
                end
                S_CI_PR: begin
                    sres  = sat_shift(r_sum + p66);
                    n_t   = sres.val;
                    n_ovf = r_ovf | sres.ovf;
                end
                S_PI_XI: begin
                    sres  = sat_shift(r_sum - p66);
                    n_pr  = sres.val;
                    n_ovf = r_ovf | sres.ovf;
                end
                S_PI_XR: begin
                    sres  = sat_shift(r_sum + p66);
                    n_pi  = sres.val;
                    n_ovf = r_ovf | sres.ovf;
                end
                default: begin
                    n_sum = r_sum;
                end
            endcase
            // The imaginary term joins the accumulator with the first
            // power-update product.
            if (mrsp.step == S_PR_XR) begin
                sres   = sat_add(r_acci, r_t);
                n_acci = sres.val;
                n_ovf  = r_ovf | sres.ovf;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (accept && (i_in_data.req_type == REQ_EVAL)) begin
                    n_xr    = i_in_data.value_re;
                    n_xi    = i_in_data.value_im;
                    n_state = ST_PREF;
                end
            end
            ST_PREF: begin
                n_pr    = ONE;
                n_pi    = '0;
                n_accr  = '0;
                n_acci  = '0;
                n_ovf   = 1'b0;
                n_step  = S_CR_PR;
                n_term  = '0;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                n_step = r_step + t_step'(1);
                if (r_step == S_PI_XR) begin
                    if (r_term == last) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_term = r_term + AW'(1);
                    end
                end
            end
            ST_DRAIN: begin
                n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (!r_ov || !i_out_stall) begin
                    n_out.result_re = r_accr;
                    n_out.result_im = r_acci;
                    n_out.overflow  = r_ovf;
                    n_ov            = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_degree <= '0;
            r_ov     <= 1'b0;
            r_step   <= S_CR_PR;
            r_term   <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_step  <= n_step;
            r_term  <= n_term;
            if (i_cfg_we) begin
                r_degree <= i_cfg_wdata;
            end
        end
        r_xr   <= n_xr;
        r_xi   <= n_xi;
        r_pr   <= n_pr;
        r_pi   <= n_pi;
        r_accr <= n_accr;
        r_acci <= n_acci;
        r_t    <= n_t;
        r_sum  <= n_sum;
        r_ovf  <= n_ovf;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_mul_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mrsp.valid |-> $past(r_state == ST_RUN))
        else $error("multiplier product without an issuing run cycle");

    a_drain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> (mrsp.valid && (mrsp.step == S_PI_XR)))
        else $error("drain cycle does not consume the final power product");

    a_pref_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREF) |=> (r_state == ST_RUN) && (r_term == '0))
        else $error("prefetch not followed by the first term");

    a_result_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !$past(r_ov && i_out_stall)) |-> $past(r_state == ST_HOLD))
        else $error("result loaded outside the hold state");

endmodule

`default_nettype wire

>>> sv/cpe_mul.sv
// Shared 32 x 32 signed multiplier with a registered product and step tag.
// Depends on cpe_pkg for the request and response structs.
`default_nettype none

module cpe_mul
    import cpe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_mul_req i_req,
    output t_mul_rsp      o_rsp
);

    logic signed [63:0] prod;
    t_mul_rsp           r_rsp;

    assign prod = i_req.a * i_req.b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp.valid <= 1'b0;
        end else begin
            r_rsp.valid <= i_req.valid;
        end
        r_rsp.step <= i_req.step;
        r_rsp.prod <= prod;
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

>>> sv/cpe_coef_mem.sv
// Coefficient table: one write port, one registered read port, and a valid
// bit per entry so that entries read as zero until they are loaded.
// Depends on cpe_pkg for the complex entry type.
`default_nettype none

module cpe_coef_mem
    import cpe_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_cpx          i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_cpx               o_rdata
);

    t_cpx             mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_cpx             r_rdata;
    logic             r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

`default_nettype wire
